@@ src/ir_remote_frame_decoder_macros.svh @@
// Assertion macros for the IR remote frame decoder checker.
// Included by irfd_checker.sv; no other dependencies.
`ifndef IR_REMOTE_FRAME_DECODER_MACROS_SVH
`define IR_REMOTE_FRAME_DECODER_MACROS_SVH

// Property checked while out of reset
`define IRFD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("irfd assertion failed");

// Property checked at every edge, reset included
`define IRFD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("irfd assertion failed");

`endif

@@ src/irfd_pkg.sv @@
// Shared types and constants of the IR remote frame decoder.
// No dependencies; used by every other file of the block but the macros header.
package irfd_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned IdxW     = 6;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_START_MIN = 3'd0,
    REG_START_MAX = 3'd1,
    REG_ZERO_MIN  = 3'd2,
    REG_ZERO_MAX  = 3'd3,
    REG_ONE_MIN   = 3'd4,
    REG_ONE_MAX   = 3'd5
  } cfg_reg_e;

  // Reset values of the gap windows, in counter ticks
  localparam logic [CfgDataW-1:0] StartMinRst = 32'd520000;
  localparam logic [CfgDataW-1:0] StartMaxRst = 32'd560000;
  localparam logic [CfgDataW-1:0] ZeroMinRst  = 32'd33750;
  localparam logic [CfgDataW-1:0] ZeroMaxRst  = 32'd56250;
  localparam logic [CfgDataW-1:0] OneMinRst   = 32'd78750;
  localparam logic [CfgDataW-1:0] OneMaxRst   = 32'd101250;

  // Edge counter codes within a frame
  localparam logic [IdxW-1:0] IdxIdle    = 6'd0;
  localparam logic [IdxW-1:0] IdxLeader  = 6'd1;
  localparam logic [IdxW-1:0] IdxBit0    = 6'd2;
  localparam logic [IdxW-1:0] FrameEdges = 6'd34;

  typedef struct packed {
    logic [TimeW-1:0] start_min;
    logic [TimeW-1:0] start_max;
    logic [TimeW-1:0] zero_min;
    logic [TimeW-1:0] zero_max;
    logic [TimeW-1:0] one_min;
    logic [TimeW-1:0] one_max;
  } cfg_regs_t;

  // Verdict on one gap
  typedef struct packed {
    logic start_ok;
    logic bit_ok;
    logic bit_val;
  } gap_class_t;

  typedef struct packed {
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] command;
    logic             frame_ok;
    logic [ByteW-1:0] held_code;
  } frame_res_t;

endpackage

@@ src/irfd_if.sv @@
// Valid/ready channel interfaces of the IR remote frame decoder.
// Depends on irfd_pkg for the field widths.
interface irfd_edge_if;
  import irfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink   (input valid, input edge_time, output ready);
endinterface

interface irfd_frame_if;
  import irfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] address;
  logic [ByteW-1:0] command;
  logic             frame_ok;
  logic [ByteW-1:0] held_code;

  modport source (output valid, output address, output command, output frame_ok,
                  output held_code, input ready);
  modport sink   (input valid, input address, input command, input frame_ok,
                  input held_code, output ready);
endinterface

@@ src/ir_remote_frame_decoder.sv @@
// IR remote frame decoder: takes falling-edge timestamps and emits one result
// word per complete frame (leader and 32 data bits). An accepted edge is held in the
// input register; while it sits there, the gap subtract, the eight window compares
// and the frame state update run, and a result is written to the output register.
// Sustained rate is one edge per cycle, limited only by the output register:
// while a result waits unread, one more edge is held in the input register,
// then ready drops. The user writes windows through the cfg port only while
// no frame is in flight; the block itself does not enforce this.
// Depends on irfd_pkg, irfd_if, irfd_cfg_regs, irfd_gap_class, irfd_frame_core.
module ir_remote_frame_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [irfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [irfd_pkg::CfgDataW-1:0] cfg_wdata_i,
  irfd_edge_if.sink                    edge_i,
  irfd_frame_if.source                 frame_o
);
  import irfd_pkg::*;

  cfg_regs_t        regs;
  gap_class_t       gap_cls;
  frame_res_t       res;
  logic             res_valid;
  logic [TimeW-1:0] prev_time;

  logic             in_valid_q, in_valid_d;
  logic [TimeW-1:0] in_time_q;
  logic             step;
  logic             take;

  // Input register handshake
  assign step        = in_valid_q && (!res_valid || frame_o.ready);
  assign edge_i.ready = !in_valid_q || step;
  assign take        = edge_i.valid && edge_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_time_q <= edge_i.edge_time;
    end
  end

  irfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .regs_o      (regs)
  );

  irfd_gap_class u_class (
    .edge_time_i (in_time_q),
    .prev_time_i (prev_time),
    .regs_i      (regs),
    .class_o     (gap_cls)
  );

  irfd_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .edge_time_i (in_time_q),
    .class_i     (gap_cls),
    .res_ready_i (frame_o.ready),
    .prev_time_o (prev_time),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result channel
  assign frame_o.valid     = res_valid;
  assign frame_o.address   = res.address;
  assign frame_o.command   = res.command;
  assign frame_o.frame_ok  = res.frame_ok;
  assign frame_o.held_code = res.held_code;

endmodule

@@ src/irfd_cfg_regs.sv @@
// Gap window register file of the IR remote frame decoder.
// Depends on irfd_pkg.
module irfd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [irfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [irfd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output irfd_pkg::cfg_regs_t          regs_o
);
  import irfd_pkg::*;

  cfg_regs_t regs_q, regs_d;

  // Write decode; unknown indexes are ignored
  always_comb begin
    regs_d = regs_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_START_MIN: regs_d.start_min = cfg_wdata_i;
        REG_START_MAX: regs_d.start_max = cfg_wdata_i;
        REG_ZERO_MIN:  regs_d.zero_min  = cfg_wdata_i;
        REG_ZERO_MAX:  regs_d.zero_max  = cfg_wdata_i;
        REG_ONE_MIN:   regs_d.one_min   = cfg_wdata_i;
        REG_ONE_MAX:   regs_d.one_max   = cfg_wdata_i;
        default:       regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.start_min <= StartMinRst;
      regs_q.start_max <= StartMaxRst;
      regs_q.zero_min  <= ZeroMinRst;
      regs_q.zero_max  <= ZeroMaxRst;
      regs_q.one_min   <= OneMinRst;
      regs_q.one_max   <= OneMaxRst;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

@@ src/irfd_gap_class.sv @@
// Gap measurement and window classification of the IR remote frame decoder.
// Depends on irfd_pkg.
module irfd_gap_class (
  input  logic [irfd_pkg::TimeW-1:0] edge_time_i,
  input  logic [irfd_pkg::TimeW-1:0] prev_time_i,
  input  irfd_pkg::cfg_regs_t        regs_i,
  output irfd_pkg::gap_class_t       class_o
);
  import irfd_pkg::*;

  logic [TimeW-1:0] gap;
  logic             in_zero;
  logic             in_one;

  // Gap wraps modulo 2^32 with the counter
  assign gap = edge_time_i - prev_time_i;

  // Inclusive windows
  assign in_zero = (gap >= regs_i.zero_min) && (gap <= regs_i.zero_max);
  assign in_one  = (gap >= regs_i.one_min) && (gap <= regs_i.one_max);

  assign class_o.start_ok = (gap >= regs_i.start_min) && (gap <= regs_i.start_max);
  assign class_o.bit_ok   = in_zero || in_one;
  // A one bit needs the gap strictly inside the one window
  assign class_o.bit_val  = (gap > regs_i.one_min) && (gap < regs_i.one_max);

endmodule

@@ src/irfd_frame_core.sv @@
// Frame state and result register of the IR remote frame decoder.
// Depends on irfd_pkg.
module irfd_frame_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [irfd_pkg::TimeW-1:0] edge_time_i,
  input  irfd_pkg::gap_class_t       class_i,
  input  logic                       res_ready_i,
  output logic [irfd_pkg::TimeW-1:0] prev_time_o,
  output logic                       res_valid_o,
  output irfd_pkg::frame_res_t       res_o
);
  import irfd_pkg::*;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [TimeW-1:0] prev_q, prev_d;
  logic [TimeW-1:0] bits_q, bits_d;
  logic [ByteW-1:0] last_q, last_d;
  logic             res_valid_q, res_valid_d;
  frame_res_t       res_q, res_d;

  logic [IdxW-1:0]  idx_inc;
  logic [4:0]       bit_pos;
  logic [TimeW-1:0] bits_new;
  logic             emit;
  logic             ok;
  logic [ByteW-1:0] held;

  assign idx_inc  = idx_q + 6'd1;
  assign bit_pos  = idx_q[4:0] - 5'd2;
  assign bits_new = bits_q | ({{(TimeW-1){1'b0}}, class_i.bit_val} << bit_pos);

  // Byte check on the completed word
  assign ok   = (bits_new[7:0] == ~bits_new[15:8]) && (bits_new[23:16] == ~bits_new[31:24]);
  assign held = ok ? bits_new[23:16] : last_q;

  // Frame sequencing per accepted edge
  always_comb begin
    idx_d  = idx_q;
    prev_d = prev_q;
    bits_d = bits_q;
    emit   = 1'b0;
    if (step_i) begin
      case (idx_q)
        IdxIdle: begin
          prev_d = edge_time_i;
          bits_d = '0;
          idx_d  = IdxLeader;
        end
        IdxLeader: begin
          if (class_i.start_ok) begin
            prev_d = edge_time_i;
            idx_d  = IdxBit0;
          end else begin
            idx_d = IdxIdle;
          end
        end
        default: begin
          if (!class_i.bit_ok) begin
            idx_d = IdxIdle;
          end else begin
            bits_d = bits_new;
            prev_d = edge_time_i;
            if ((idx_inc >= FrameEdges) || (idx_inc == IdxIdle)) begin
              emit  = 1'b1;
              idx_d = IdxIdle;
            end else begin
              idx_d = idx_inc;
            end
          end
        end
      endcase
    end
  end

  // Result register and held code
  always_comb begin
    last_d      = last_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    if (emit) begin
      last_d          = held;
      res_d.address   = bits_new[7:0];
      res_d.command   = bits_new[23:16];
      res_d.frame_ok  = ok;
      res_d.held_code = held;
      res_valid_d     = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IdxIdle;
      prev_q      <= '0;
      bits_q      <= '0;
      last_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      prev_q      <= prev_d;
      bits_q      <= bits_d;
      last_q      <= last_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign prev_time_o = prev_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ src/irfd_checker.sv @@
// Port-level checks of the IR remote frame decoder, bound to the top level.
// Depends on irfd_pkg and ir_remote_frame_decoder_macros.svh.
`include "ir_remote_frame_decoder_macros.svh"

module irfd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [irfd_pkg::ByteW-1:0] command_i,
  input logic                       frame_ok_i,
  input logic [irfd_pkg::ByteW-1:0] held_code_i
);
  import irfd_pkg::*;

  // A passing frame updates the held code to its own command
  `IRFD_ASSERT(a_held_follows_ok, clk_i, rst_ni, (out_valid_i && frame_ok_i) |-> (held_code_i == command_i))

  // With no result pending the block always takes an edge
  `IRFD_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_i |-> in_ready_i)

  // A stalled result stays and keeps its payload
  `IRFD_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(command_i) && $stable(held_code_i)))

  // No result while in reset
  `IRFD_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_i)

endmodule

bind ir_remote_frame_decoder irfd_checker u_irfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (edge_i.ready),
  .out_valid_i (frame_o.valid),
  .out_ready_i (frame_o.ready),
  .command_i   (frame_o.command),
  .frame_ok_i  (frame_o.frame_ok),
  .held_code_i (frame_o.held_code)
);

@@ dv/ir_remote_frame_decoder_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ir_remote_frame_decoder: drives edge timestamps and
// window settings, predicts frames and checks each result word. Uses irfd_pkg, irfd_if.
module ir_remote_frame_decoder_test;
  import irfd_pkg::*;

  localparam int unsigned CycleLimit  = 500000;  // ~2k edges over all phases, with receiver stalls
  localparam int unsigned SettleCycles = 8;      // input reg + compute + output reg, padded
  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_SPARSE,
    STALL_LONG
  } stall_mode_e;

  // Predicts the decoder word by word and holds the frames still to come out
  class frame_scoreboard;
    logic [TimeW-1:0] win [6];
    logic [IdxW-1:0]  edge_cnt;
    logic [TimeW-1:0] last_time;
    logic [TimeW-1:0] bits;
    logic [ByteW-1:0] good_code;
    frame_res_t       frames_due [$];
    int unsigned      n_edges, n_frames, n_ok, n_errors;

    function void reset_state();
      win[REG_START_MIN] = StartMinRst;
      win[REG_START_MAX] = StartMaxRst;
      win[REG_ZERO_MIN]  = ZeroMinRst;
      win[REG_ZERO_MAX]  = ZeroMaxRst;
      win[REG_ONE_MIN]   = OneMinRst;
      win[REG_ONE_MAX]   = OneMaxRst;
      edge_cnt  = IdxIdle;
      last_time = '0;
      bits      = '0;
      good_code = '0;
    endfunction

    // Unmapped indexes are dropped
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
      if (idx <= REG_ONE_MAX) win[idx] = v;
    endfunction

    function bit in_win(logic [TimeW-1:0] v, logic [TimeW-1:0] lo, logic [TimeW-1:0] hi);
      return v >= lo && v <= hi;
    endfunction

    function bit gap_accepted(bit leader, logic [TimeW-1:0] g);
      if (leader) return in_win(g, win[REG_START_MIN], win[REG_START_MAX]);
      return in_win(g, win[REG_ZERO_MIN], win[REG_ZERO_MAX]) ||
             in_win(g, win[REG_ONE_MIN], win[REG_ONE_MAX]);
    endfunction

    function void note_edge(logic [TimeW-1:0] t);
      logic [TimeW-1:0] gap;
      logic [4:0]       pos;
      frame_res_t       res;
      gap = t - last_time;
      n_edges++;
      if (edge_cnt == IdxIdle) begin
        last_time = t;
        bits      = '0;
        edge_cnt  = IdxLeader;
        return;
      end
      if (edge_cnt == IdxLeader) begin
        if (gap_accepted(1'b1, gap)) begin
          last_time = t;
          edge_cnt  = IdxBit0;
        end else begin
          edge_cnt = IdxIdle;
        end
        return;
      end
      // bit phase: drop the edge when the gap fits neither window
      if (!gap_accepted(1'b0, gap)) begin
        edge_cnt = IdxIdle;
        return;
      end
      pos = 5'(edge_cnt - IdxBit0);
      if (gap > win[REG_ONE_MIN] && gap < win[REG_ONE_MAX]) bits[pos] = 1'b1;
      last_time = t;
      edge_cnt  = edge_cnt + 1'b1;
      if (edge_cnt < FrameEdges && edge_cnt >= IdxBit0) return;
      edge_cnt     = IdxIdle;
      res.address  = bits[7:0];
      res.command  = bits[23:16];
      res.frame_ok = (bits[7:0] == ~bits[15:8]) && (bits[23:16] == ~bits[31:24]);
      if (res.frame_ok) good_code = res.command;
      res.held_code = good_code;
      frames_due.push_back(res);
    endfunction

    function void check_frame(frame_res_t got);
      frame_res_t exp_res;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame word addr %h cmd %h ok %b held %h", $time,
                 got.address, got.command, got.frame_ok, got.held_code);
        n_errors++;
        return;
      end
      exp_res = frames_due.pop_front();
      n_frames++;
      if (exp_res.frame_ok) n_ok++;
      if (got.address !== exp_res.address) begin
        $display("%0t: address expected %h actual %h", $time, exp_res.address, got.address);
        n_errors++;
      end
      if (got.command !== exp_res.command) begin
        $display("%0t: command expected %h actual %h", $time, exp_res.command, got.command);
        n_errors++;
      end
      if (got.frame_ok !== exp_res.frame_ok) begin
        $display("%0t: frame_ok expected %b actual %b", $time, exp_res.frame_ok, got.frame_ok);
        n_errors++;
      end
      if (got.held_code !== exp_res.held_code) begin
        $display("%0t: held_code expected %h actual %h", $time, exp_res.held_code,
                 got.held_code);
        n_errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  irfd_edge_if  edge_if ();
  irfd_frame_if frame_if ();

  frame_scoreboard sb;
  int unsigned     cycles = 0;
  int unsigned     burst_left = 0;
  int unsigned     n_settings = 1;
  stall_mode_e     pat_mode = STALL_NONE;
  int unsigned     pat_left = 0;

  ir_remote_frame_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .edge_i      (edge_if),
    .frame_o     (frame_if)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver stalls: modes switch after random stretches
  always @(posedge clk_i) begin
    if (pat_left == 0) begin
      pat_mode <= stall_mode_e'($urandom_range(0, 3));
      pat_left <= $urandom_range(16, 300);
    end else begin
      pat_left <= pat_left - 1;
    end
    case (pat_mode)
      STALL_NONE:   frame_if.ready <= 1'b1;
      STALL_RANDOM: frame_if.ready <= 1'($urandom_range(0, 1));
      STALL_SPARSE: frame_if.ready <= (cycles % 5 == 0);
      default:      frame_if.ready <= (cycles % 24 >= 20);
    endcase
  end

  // Result monitor
  always @(posedge clk_i) begin
    frame_res_t got;
    if (rst_ni && frame_if.valid && frame_if.ready) begin
      got.address   = frame_if.address;
      got.command   = frame_if.command;
      got.frame_ok  = frame_if.frame_ok;
      got.held_code = frame_if.held_code;
      sb.check_frame(got);
    end
  end

  // One edge word; the sender idles between bursts
  task automatic send_edge(logic [TimeW-1:0] t);
    if (burst_left == 0) begin
      edge_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    edge_if.valid     <= 1'b1;
    edge_if.edge_time <= t;
    do @(posedge clk_i); while (!edge_if.ready);
    sb.note_edge(t);
  endtask

  task automatic send_gap(logic [TimeW-1:0] g);
    send_edge(sb.last_time + g);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic write_windows(logic [TimeW-1:0] s_lo, logic [TimeW-1:0] s_hi,
                               logic [TimeW-1:0] z_lo, logic [TimeW-1:0] z_hi,
                               logic [TimeW-1:0] o_lo, logic [TimeW-1:0] o_hi);
    cfg_write(REG_START_MIN, s_lo);
    cfg_write(REG_START_MAX, s_hi);
    cfg_write(REG_ZERO_MIN, z_lo);
    cfg_write(REG_ZERO_MAX, z_hi);
    cfg_write(REG_ONE_MIN, o_lo);
    cfg_write(REG_ONE_MAX, o_hi);
    cfg_write(RegUnmapped, $urandom);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Random value in [lo, hi] with the bounds favored
  function automatic logic [TimeW-1:0] pick_in(logic [TimeW-1:0] lo, logic [TimeW-1:0] hi);
    case ($urandom_range(0, 9))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [TimeW-1:0] leader_gap();
    if (sb.win[REG_START_MIN] <= sb.win[REG_START_MAX])
      return pick_in(sb.win[REG_START_MIN], sb.win[REG_START_MAX]);
    return $urandom;
  endfunction

  // Aims for the wanted bit; falls back to a zero bit where a one cannot be coded
  function automatic logic [TimeW-1:0] bit_gap(bit b);
    logic [TimeW-1:0] o_lo, o_hi, z_lo, z_hi, g;
    o_lo = sb.win[REG_ONE_MIN];
    o_hi = sb.win[REG_ONE_MAX];
    z_lo = sb.win[REG_ZERO_MIN];
    z_hi = sb.win[REG_ZERO_MAX];
    if (b && o_hi > o_lo && o_hi - o_lo >= 2) return pick_in(o_lo + 1, o_hi - 1);
    if (z_lo <= z_hi) begin
      g = pick_in(z_lo, z_hi);
      if (!(g > o_lo && g < o_hi)) return g;
    end
    if (o_lo <= o_hi) return $urandom_range(0, 1) ? o_lo : o_hi;
    return $urandom;
  endfunction

  // Looks for a gap the current phase rejects; none exists when windows cover all
  function automatic bit bad_gap(bit leader, output logic [TimeW-1:0] g);
    logic [TimeW-1:0] lo, hi;
    for (int i = 0; i < 12; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          lo = leader ? sb.win[REG_START_MIN] : sb.win[REG_ZERO_MIN];
          hi = leader ? sb.win[REG_START_MAX] : sb.win[REG_ZERO_MAX];
        end
        1: begin
          lo = leader ? sb.win[REG_START_MIN] : sb.win[REG_ONE_MIN];
          hi = leader ? sb.win[REG_START_MAX] : sb.win[REG_ONE_MAX];
        end
        default: begin
          lo = $urandom;
          hi = lo;
        end
      endcase
      g = $urandom_range(0, 1) ? lo - 1'b1 : hi + 1'b1;
      if (!sb.gap_accepted(leader, g)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Brings the decoder back to idle, by a rejected gap or by finishing the frame
  task automatic drain_to_idle();
    logic [TimeW-1:0] g;
    while (sb.edge_cnt != IdxIdle) begin
      if (!bad_gap(sb.edge_cnt == IdxLeader, g))
        g = (sb.edge_cnt == IdxLeader) ? leader_gap() : bit_gap(1'($urandom_range(0, 1)));
      send_gap(g);
    end
  endtask

  // Mostly well-formed frames with random content; some broken, some plain noise
  task automatic gen_frame();
    int unsigned      kind, brk;
    logic [ByteW-1:0] a, c;
    logic [TimeW-1:0] payload, g;
    bit               stop;
    drain_to_idle();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 6)) send_edge($urandom);
      return;
    end
    a = 8'($urandom);
    c = 8'($urandom);
    payload = (kind < 70) ? {~c, c, ~a, a} : $urandom;
    brk  = (kind >= 88) ? $urandom_range(0, 32) : 33;
    stop = 1'b0;
    send_edge($urandom);
    for (int k = 0; k <= 32 && !stop; k++) begin
      if (k == brk && bad_gap(k == 0, g)) begin
        stop = 1'b1;
      end else begin
        g = (k == 0) ? leader_gap() : bit_gap(payload[k-1]);
      end
      send_gap(g);
    end
  endtask

  // Waits out every expected word, then the pipeline
  task automatic settle();
    edge_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.frames_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned n_words);
    int unsigned first;
    first = sb.n_edges;
    while (sb.n_edges - first < n_words) gen_frame();
    drain_to_idle();
    settle();
  endtask

  // Window bounds, wrap of the counter and dropped edges at reset windows
  task automatic directed_edges();
    send_edge(32'hFFFF_FFFF);
    send_gap(sb.win[REG_START_MAX] + 1'b1);   // leader too long
    send_gap(32'd5);
    send_gap(sb.win[REG_START_MIN] - 1'b1);   // leader too short
    send_edge('0);
    send_gap(sb.win[REG_START_MAX]);
    send_gap(sb.win[REG_ZERO_MIN]);
    send_gap(sb.win[REG_ZERO_MAX]);
    send_gap(sb.win[REG_ONE_MIN]);            // one-window bounds decode as zero
    send_gap(sb.win[REG_ONE_MAX]);
    send_gap(sb.win[REG_ONE_MIN] + 1'b1);
    send_gap(sb.win[REG_ONE_MAX] - 1'b1);
    send_gap(sb.win[REG_ZERO_MAX] + 1'b1);    // between windows
    send_edge(32'hFFFF_0000);
    send_gap(sb.win[REG_START_MIN]);          // leader wraps the counter
    send_gap(sb.win[REG_ZERO_MIN] - 1'b1);
    send_edge(32'h8000_0000);
    send_gap(sb.win[REG_START_MIN]);
    send_gap(sb.win[REG_ONE_MAX] + 1'b1);
    send_edge(32'h7FFF_FFFF);
    send_gap(sb.win[REG_START_MAX]);
    send_gap(sb.win[REG_ONE_MIN] - 1'b1);
    settle();
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_START_MIN;
    cfg_wdata_i       = '0;
    edge_if.valid     = 1'b0;
    edge_if.edge_time = '0;
    frame_if.ready    = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_edges();
    run_phase(260);
    // narrow windows
    write_windows(32'd100, 32'd200, 32'd10, 32'd20, 32'd30, 32'd40);
    run_phase(260);
    // overlapping bit windows, single-point leader
    write_windows(32'd1000, 32'd1000, 32'd10, 32'd50, 32'd30, 32'd70);
    run_phase(260);
    // empty one window: zero bits only
    write_windows(32'd500, 32'd900, 32'd5, 32'd9, 32'd40, 32'd20);
    run_phase(260);
    // empty leader window: nothing gets past the leader
    write_windows(32'd900, 32'd500, 32'd5, 32'd9, 32'd10, 32'd20);
    run_phase(60);
    // windows cover every gap
    write_windows('0, '1, '0, '1, '0, '1);
    run_phase(260);
    // top of the range
    write_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFD, 32'hFFFF_FFFF);
    run_phase(260);
    write_windows(StartMinRst, StartMaxRst, ZeroMinRst, ZeroMaxRst, OneMinRst, OneMaxRst);
    run_phase(260);

    $display("Run: %0d edge words over %0d window settings, %0d frames checked",
             sb.n_edges, n_settings, sb.n_frames);
    $display("  %0d frames passed the byte check, %0d mismatches", sb.n_ok, sb.n_errors);
    if (sb.n_errors == 0 && sb.frames_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/irfd_pkg.sv
src/irfd_if.sv
src/irfd_cfg_regs.sv
src/irfd_gap_class.sv
src/irfd_frame_core.sv
src/ir_remote_frame_decoder.sv
src/irfd_checker.sv
dv/ir_remote_frame_decoder_test.sv
